// ----- rtl/core/sfr_pkg.sv -----
// Shared types and constants for the stream find-and-replace block.
package sfr_pkg;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
  localparam int unsigned REPL_MAX    = 8;

  localparam logic [1:0] CFG_SEARCH_PATTERN     = 2'd0;
  localparam logic [1:0] CFG_PATTERN_LENGTH     = 2'd1;
  localparam logic [1:0] CFG_REPLACEMENT_TEXT   = 2'd2;
  localparam logic [1:0] CFG_REPLACEMENT_LENGTH = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_REPL,
    S_FLUSH,
    S_DONE
  } sfr_state_t;

  typedef enum logic [1:0] {
    EM_NONE,
    EM_WIN,
    EM_REPL,
    EM_NL
  } emit_src_t;

  typedef struct packed {
    logic      load;
    logic      line_set;
    logic      line_clr;
    emit_src_t emit;
    logic      clr_cnt;
    logic      finish;
  } sfr_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic prefix;
    logic short_win;
    logic rlen_zero;
    logic repl_last;
    logic emit_ok;
    logic hold_v;
    logic in_nl;
    logic in_flush;
    logic line_open;
  } sfr_status_t;

endpackage

// ----- rtl/core/stream_find_replace.sv -----
// Top level of the streaming find-and-replace block.
//
//   channel  direction  payload
//   in_      slave      tdata: data_byte[7:0]; tuser: req_type (1 = end of input)
//   out_     master     tdata: out_byte[7:0];  tlast: last_of_run
//   cfg_     write      index 0..3 -> pattern, pattern length, replacement, repl. length
//
// One word in at a time: an accept step, then scan steps or output bytes, then a closing
// step. A text byte takes one extra scan step that decides match, hold or empty window.
// The work per word is bounded by the single window compare and one-byte emit path.
// Synchronous active-low reset clears control, counts and configuration.
// A stalled output holds the emit path; input stays unready until the word finishes.
module stream_find_replace
  import sfr_pkg::*;
#(
  parameter int MAX_PATTERN = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte[7:0]
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte[7:0]
  output logic        out_tlast
);

  sfr_cmd_t    cmd;
  sfr_status_t sts;

  sfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sfr_dp #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// ----- rtl/core/sfr_ctrl.sv -----
// Controller state machine for the stream find-and-replace block.
module sfr_ctrl
  import sfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  sfr_status_t sts,
  output sfr_cmd_t    cmd
);

  sfr_state_t state_r, state_nxt;
  logic       accept;

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (sts.in_flush) begin
            state_nxt = (sts.line_open || !sts.cnt_zero) ? S_FLUSH : S_DONE;
          end else if (sts.in_nl) begin
            state_nxt = S_FLUSH;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (sts.cnt_zero) begin
          state_nxt = S_DONE;
        end else if (sts.prefix && sts.short_win) begin
          state_nxt = S_DONE;
        end else if (sts.prefix) begin
          state_nxt = sts.rlen_zero ? S_DONE : S_REPL;
        end
      end
      S_REPL: begin
        if (sts.emit_ok && sts.repl_last) begin
          state_nxt = S_DONE;
        end
      end
      S_FLUSH: begin
        if (sts.emit_ok && sts.cnt_zero) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.hold_v || sts.emit_ok) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.emit  = EM_NONE;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (accept) begin
          if (sts.in_flush || sts.in_nl) begin
            cmd.line_clr = 1'b1;
          end else begin
            cmd.load     = 1'b1;
            cmd.line_set = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (!sts.cnt_zero && sts.prefix && !sts.short_win) begin
          // full match: a deletion empties the window here, else after the last byte
          cmd.clr_cnt = sts.rlen_zero;
        end else if (!sts.cnt_zero && !sts.prefix && sts.emit_ok) begin
          cmd.emit = EM_WIN;
        end
      end
      S_REPL: begin
        if (sts.emit_ok) begin
          cmd.emit    = EM_REPL;
          cmd.clr_cnt = sts.repl_last;
        end
      end
      S_FLUSH: begin
        if (sts.emit_ok) begin
          cmd.emit = sts.cnt_zero ? EM_NL : EM_WIN;
        end
      end
      S_DONE: begin
        cmd.finish = sts.hold_v && sts.emit_ok;
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/sfr_dp.sv -----
// Datapath: configuration, match window, replacement index and output staging.
module sfr_dp
  import sfr_pkg::*;
#(
  parameter int MAX_PATTERN = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,
  output logic        out_tlast,
  input  sfr_cmd_t    cmd,
  output sfr_status_t sts
);

  localparam int CW = $clog2(MAX_PATTERN + 1);
  localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [3:0] MAXP4 = 4'(MAX_PATTERN);
  localparam logic [3:0] RMAX4 = 4'(REPL_MAX);

  logic [63:0]   pat_r, pat_nxt;
  logic [3:0]    plen_raw_r, plen_raw_nxt;
  logic [63:0]   repl_r, repl_nxt;
  logic [3:0]    rlen_raw_r, rlen_raw_nxt;
  logic [7:0]    win_r [MAX_PATTERN];
  logic [7:0]    win_nxt [MAX_PATTERN];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          line_open_r, line_open_nxt;
  logic [2:0]    idx_r, idx_nxt;
  logic [7:0]    hold_r, hold_nxt;
  logic          hold_v_r, hold_v_nxt;
  logic [7:0]    out_data_r, out_data_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [3:0]    plen4;
  logic [CW-1:0] plen;
  logic [3:0]    rlen;
  logic          mism;
  logic          emitting;
  logic [7:0]    emit_byte;

  // effective lengths: zero pattern acts as one, both clamp at their maxima
  always_comb begin
    plen4 = plen_raw_r;
    if (plen4 == 4'd0) plen4 = 4'd1;
    if (plen4 > MAXP4) plen4 = MAXP4;
    plen = CW'(plen4);
    rlen = (rlen_raw_r > RMAX4) ? RMAX4 : rlen_raw_r;
  end

  always_comb begin
    mism = 1'b0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((CW'(i) < cnt_r) && (CW'(i) < plen) && (win_r[i] != pat_r[8*i +: 8])) begin
        mism = 1'b1;
      end
    end
  end

  assign sts.cnt_zero  = (cnt_r == '0);
  assign sts.prefix    = !mism;
  assign sts.short_win = (cnt_r < plen);
  assign sts.rlen_zero = (rlen == 4'd0);
  assign sts.repl_last = ({1'b0, idx_r} == (rlen - 4'd1));
  assign sts.emit_ok   = !hold_v_r || !out_valid_r || out_tready;
  assign sts.hold_v    = hold_v_r;
  assign sts.in_nl     = (in_tdata == NEWLINE_BYTE);
  assign sts.in_flush  = in_tuser;
  assign sts.line_open = line_open_r;

  assign emitting = (cmd.emit != EM_NONE);

  always_comb begin
    case (cmd.emit)
      EM_WIN:  emit_byte = win_r[0];
      EM_REPL: emit_byte = repl_r[8*idx_r +: 8];
      EM_NL:   emit_byte = NEWLINE_BYTE;
      default: emit_byte = hold_r;
    endcase
  end

  always_comb begin
    pat_nxt       = pat_r;
    plen_raw_nxt  = plen_raw_r;
    repl_nxt      = repl_r;
    rlen_raw_nxt  = rlen_raw_r;
    win_nxt       = win_r;
    cnt_nxt       = cnt_r;
    line_open_nxt = line_open_r;
    idx_nxt       = idx_r;
    hold_nxt      = hold_r;
    hold_v_nxt    = hold_v_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_tready;

    if (cfg_we) begin
      case (cfg_index)
        CFG_SEARCH_PATTERN: begin
          pat_nxt = cfg_data;
          cnt_nxt = '0;
        end
        CFG_PATTERN_LENGTH: begin
          plen_raw_nxt = cfg_data[3:0];
          cnt_nxt      = '0;
        end
        CFG_REPLACEMENT_TEXT:   repl_nxt     = cfg_data;
        CFG_REPLACEMENT_LENGTH: rlen_raw_nxt = cfg_data[3:0];
        default: ;
      endcase
    end

    if (cmd.load) begin
      win_nxt[cnt_r[IW-1:0]] = in_tdata;
      cnt_nxt                = cnt_r + CW'(1);
      idx_nxt                = '0;
    end
    if (cmd.line_set) line_open_nxt = 1'b1;
    if (cmd.line_clr) line_open_nxt = 1'b0;

    if (cmd.emit == EM_WIN) begin
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
        win_nxt[i] = win_r[i+1];
      end
      cnt_nxt = cnt_r - CW'(1);
    end
    if (cmd.emit == EM_REPL) idx_nxt = idx_r + 3'd1;
    if (cmd.clr_cnt) cnt_nxt = '0;

    // one word is held back so the last word of an item can carry tlast
    if (emitting) begin
      if (hold_v_r) begin
        out_data_nxt  = hold_r;
        out_last_nxt  = 1'b0;
        out_valid_nxt = 1'b1;
      end
      hold_nxt   = emit_byte;
      hold_v_nxt = 1'b1;
    end
    if (cmd.finish) begin
      out_data_nxt  = hold_r;
      out_last_nxt  = 1'b1;
      out_valid_nxt = 1'b1;
      hold_v_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r       <= '0;
      plen_raw_r  <= 4'd1;
      repl_r      <= '0;
      rlen_raw_r  <= 4'd0;
      cnt_r       <= '0;
      line_open_r <= 1'b0;
      idx_r       <= '0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pat_r       <= pat_nxt;
      plen_raw_r  <= plen_raw_nxt;
      repl_r      <= repl_nxt;
      rlen_raw_r  <= rlen_raw_nxt;
      cnt_r       <= cnt_nxt;
      line_open_r <= line_open_nxt;
      idx_r       <= idx_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r      <= win_nxt;
    hold_r     <= hold_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
